// ===== rtl/core/ics_pkg.sv =====
// Shared types and codes for the Ichimoku cloud signal unit.
`default_nettype none
package ics_pkg;
    localparam int IN_W  = 32;
    localparam int OUT_W = 34;

    typedef logic [1:0] t_code;

    localparam t_code SIG_NONE = 2'd0;
    localparam t_code SIG_BUY  = 2'd1;
    localparam t_code SIG_SELL = 2'd2;

    localparam t_code STR_NONE   = 2'd0;
    localparam t_code STR_WEAK   = 2'd1;
    localparam t_code STR_MEDIUM = 2'd2;
    localparam t_code STR_STRONG = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CALC,
        ST_EMIT
    } t_state;
endpackage
`default_nettype wire

// ===== rtl/core/ics_if.sv =====
// Candle input and indicator output channel interfaces.
`default_nettype none
interface ics_in_if import ics_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IN_W-1:0]  high_price;
    logic [IN_W-1:0]  low_price;
    logic [IN_W-1:0]  close_price;
    modport source (output valid, high_price, low_price, close_price, input ready);
    modport sink   (input valid, high_price, low_price, close_price, output ready);
endinterface

interface ics_out_if import ics_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] conversion_line;
    logic [OUT_W-1:0] base_line;
    logic [OUT_W-1:0] cloud_span_a;
    logic [OUT_W-1:0] cloud_span_b;
    logic [1:0]       signal;
    logic [1:0]       strength;
    modport source (output valid, conversion_line, base_line, cloud_span_a, cloud_span_b,
                    signal, strength, input ready);
    modport sink   (input valid, conversion_line, base_line, cloud_span_a, cloud_span_b,
                    signal, strength, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ichimoku_cloud_signal_unit.sv =====
// Ichimoku cloud signal unit: candle in, indicator lines and trade signal out.
// Usage:
//   i_in carries one candle per transaction (high, low, close in ticks); only the
//   low PRICE_BITS of each price count. o_out carries one result per candle:
//   conversion and base lines, the two cloud spans delayed SHIFT_LEN candles,
//   and a buy/sell signal with its strength, all lines in quarter ticks.
// Timing:
//   A candle is accepted, then scanned over the whole history, then its lines
//   are calculated and committed (HistDepth = largest window, 52 by default).
//   The high/low history is a row of cells that rotates once per candle; during
//   the scan one cell leaves the tail each cycle and feeds the three running
//   max/min windows. That rotation sets how fast candles can be taken.
//   i_in.ready is high only while no candle is being worked on.
// Stall:
//   The result sits in an output register; a new candle may be accepted and
//   scanned while it waits, and the next result waits until the register is free.
// Reset:
//   Synchronous, active low. Clears the candle count, the span delay lines and
//   the previous lines; no clearing pass is needed.
`default_nettype none
module ichimoku_cloud_signal_unit import ics_pkg::*; #(
    parameter int CONVERSION_LEN = 9,
    parameter int BASE_LEN       = 26,
    parameter int SPAN_B_LEN     = 52,
    parameter int SHIFT_LEN      = 26,
    parameter int PRICE_BITS     = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ics_in_if.sink     i_in,
    ics_out_if.source  o_out
);
    localparam int HistDepth = (CONVERSION_LEN > BASE_LEN ?
                                (CONVERSION_LEN > SPAN_B_LEN ? CONVERSION_LEN : SPAN_B_LEN) :
                                (BASE_LEN > SPAN_B_LEN ? BASE_LEN : SPAN_B_LEN));
    localparam int CW = $clog2(HistDepth);
    localparam int SW = $clog2(HistDepth + 1);
    localparam int PB = PRICE_BITS;
    localparam int MW = PRICE_BITS + 2;

    t_state r_state, n_state;
    logic [CW-1:0] r_cnt;
    logic [SW-1:0] r_seen;

    logic w_accept, w_scan, w_commit;

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_scan     = (r_state == ST_SCAN);

    logic [PB-1:0] w_high, w_low, w_close;
    assign w_high  = PB'(i_in.high_price);
    assign w_low   = PB'(i_in.low_price);
    assign w_close = PB'(i_in.close_price);

    // high/low history ring: shift in on accept, rotate during the scan
    logic [2*PB-1:0] w_hist_q [HistDepth];
    logic [2*PB-1:0] w_hist_d [HistDepth];
    logic            w_hist_en;
    assign w_hist_en   = w_accept || w_scan;
    assign w_hist_d[0] = w_scan ? w_hist_q[HistDepth-1] : {w_high, w_low};

    for (genvar k = 0; k < HistDepth; k++) begin : g_hist
        if (k > 0) begin : g_link
            assign w_hist_d[k] = w_hist_q[k-1];
        end
        ics_cell #(.W(2*PB)) u_cell (
            .i_clk (i_clk),
            .i_en  (w_hist_en),
            .i_d   (w_hist_d[k]),
            .o_q   (w_hist_q[k])
        );
    end

    // close history: cell 0 is the current close
    logic [PB-1:0] w_close_q [SHIFT_LEN];
    for (genvar k = 0; k < SHIFT_LEN; k++) begin : g_close
        logic [PB-1:0] w_d;
        if (k == 0) begin : g_head
            assign w_d = w_close;
        end else begin : g_link
            assign w_d = w_close_q[k-1];
        end
        ics_cell #(.W(PB)) u_cell (
            .i_clk (i_clk),
            .i_en  (w_accept),
            .i_d   (w_d),
            .o_q   (w_close_q[k])
        );
    end

    // span A / span B delay line
    logic [2*MW-1:0] w_dly_q [SHIFT_LEN];
    logic [MW-1:0]   w_mid;
    logic [MW-1:0]   r_spanb;
    for (genvar k = 0; k < SHIFT_LEN; k++) begin : g_dly
        logic [2*MW-1:0] w_d;
        if (k == 0) begin : g_head
            assign w_d = {w_mid, r_spanb};
        end else begin : g_link
            assign w_d = w_dly_q[k-1];
        end
        ics_delay_cell #(.W(2*MW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_commit),
            .i_d     (w_d),
            .o_q     (w_dly_q[k])
        );
    end

    // window scan: the tail cell holds age HistDepth-1-r_cnt
    logic [PB-1:0] r_hi_c, r_lo_c, r_hi_b, r_lo_b, r_hi_s, r_lo_s;
    logic [PB-1:0] w_tail_hi, w_tail_lo;
    logic [SW-1:0] w_age, w_n_c, w_n_b, w_n_s;
    assign w_tail_hi = w_hist_q[HistDepth-1][2*PB-1:PB];
    assign w_tail_lo = w_hist_q[HistDepth-1][PB-1:0];
    assign w_age     = SW'(HistDepth - 1) - SW'(r_cnt);
    assign w_n_c = (r_seen < SW'(CONVERSION_LEN)) ? r_seen : SW'(CONVERSION_LEN);
    assign w_n_b = (r_seen < SW'(BASE_LEN))       ? r_seen : SW'(BASE_LEN);
    assign w_n_s = (r_seen < SW'(SPAN_B_LEN))     ? r_seen : SW'(SPAN_B_LEN);

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_hi_c <= '0;
            r_hi_b <= '0;
            r_hi_s <= '0;
            r_lo_c <= '1;
            r_lo_b <= '1;
            r_lo_s <= '1;
        end else if (w_scan) begin
            if (w_age < w_n_c) begin
                if (w_tail_hi > r_hi_c) r_hi_c <= w_tail_hi;
                if (w_tail_lo < r_lo_c) r_lo_c <= w_tail_lo;
            end
            if (w_age < w_n_b) begin
                if (w_tail_hi > r_hi_b) r_hi_b <= w_tail_hi;
                if (w_tail_lo < r_lo_b) r_lo_b <= w_tail_lo;
            end
            if (w_age < w_n_s) begin
                if (w_tail_hi > r_hi_s) r_hi_s <= w_tail_hi;
                if (w_tail_lo < r_lo_s) r_lo_s <= w_tail_lo;
            end
        end
    end

    // midpoints in quarter ticks: 2 * (max high + min low)
    logic [MW-1:0] r_conv, r_base;
    always_ff @(posedge i_clk) begin
        if (r_state == ST_CALC) begin
            r_conv  <= MW'({1'b0, r_hi_c} + {1'b0, r_lo_c}) << 1;
            r_base  <= MW'({1'b0, r_hi_b} + {1'b0, r_lo_b}) << 1;
            r_spanb <= MW'({1'b0, r_hi_s} + {1'b0, r_lo_s}) << 1;
        end
    end

    // signal decision
    logic [MW-1:0] r_prev_conv, r_prev_base;
    logic [MW-1:0] w_cloud_a, w_cloud_b, w_top, w_bottom, w_close_q4;
    logic [PB-1:0] w_back, w_cur;
    logic          w_crossed, w_buy, w_sell;
    t_code         w_grade, w_sig, w_str;

    assign w_mid      = MW'(({1'b0, r_conv} + {1'b0, r_base}) >> 1);
    assign w_cloud_a  = w_dly_q[SHIFT_LEN-1][2*MW-1:MW];
    assign w_cloud_b  = w_dly_q[SHIFT_LEN-1][MW-1:0];
    assign w_top      = (w_cloud_a > w_cloud_b) ? w_cloud_a : w_cloud_b;
    assign w_bottom   = (w_cloud_a < w_cloud_b) ? w_cloud_a : w_cloud_b;
    assign w_cur      = w_close_q[0];
    assign w_back     = w_close_q[SHIFT_LEN-1];
    assign w_close_q4 = {w_cur, 2'b00};
    assign w_crossed  = ((r_prev_conv > r_prev_base) && (r_conv < r_base)) ||
                        ((r_prev_conv < r_prev_base) && (r_conv > r_base));
    assign w_buy  = (w_close_q4 > w_top) && (r_conv > r_base) && (w_back > w_cur);
    assign w_sell = (w_close_q4 < w_bottom) && (r_conv < r_base) && (w_back < w_cur);

    always_comb begin
        if (w_mid > w_top) begin
            w_grade = STR_STRONG;
        end else if (w_mid < w_top && w_mid > w_bottom) begin
            w_grade = STR_MEDIUM;
        end else if (w_mid < w_bottom) begin
            w_grade = STR_WEAK;
        end else begin
            w_grade = STR_NONE;
        end
        w_sig = SIG_NONE;
        w_str = STR_NONE;
        if (r_seen >= SW'(SPAN_B_LEN) && w_crossed) begin
            if (w_buy) begin
                w_str = w_grade;
                w_sig = (w_grade != STR_NONE) ? SIG_BUY : SIG_NONE;
            end else if (w_sell) begin
                w_str = w_grade;
                w_sig = (w_grade != STR_NONE) ? SIG_SELL : SIG_NONE;
            end
        end
    end

    // output register
    logic r_ov;
    assign w_commit = (r_state == ST_EMIT) && (!r_ov || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov        <= 1'b0;
            r_prev_conv <= '0;
            r_prev_base <= '0;
        end else if (w_commit) begin
            r_ov        <= 1'b1;
            r_prev_conv <= r_conv;
            r_prev_base <= r_base;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            o_out.conversion_line <= OUT_W'(r_conv);
            o_out.base_line       <= OUT_W'(r_base);
            o_out.cloud_span_a    <= OUT_W'(w_cloud_a);
            o_out.cloud_span_b    <= OUT_W'(w_cloud_b);
            o_out.signal          <= w_sig;
            o_out.strength        <= w_str;
        end
    end
    assign o_out.valid = r_ov;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_seen  <= '0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_cnt <= '0;
                if (r_seen < SW'(HistDepth)) r_seen <= r_seen + 1'b1;
            end else if (w_scan) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (w_accept) n_state = ST_SCAN;
            ST_SCAN: if (r_cnt == CW'(HistDepth - 1)) n_state = ST_CALC;
            ST_CALC: n_state = ST_EMIT;
            ST_EMIT: if (w_commit) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

`ifndef SYNTH
    a_sig_has_strength: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ((o_out.signal == SIG_NONE) == (o_out.strength == STR_NONE)))
        else $error("signal and strength disagree");
    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_SCAN) && (r_cnt == '0))
        else $error("accepted candle did not start a scan");
    a_commit_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> r_ov && (r_state == ST_IDLE))
        else $error("result commit did not load the output register");
`endif
endmodule
`default_nettype wire

// ===== rtl/core/ics_cell.sv =====
// History cell: one word that takes its neighbor's word when enabled.
`default_nettype none
module ics_cell import ics_pkg::*; #(
    parameter int W = 64
) (
    input  wire logic         i_clk,
    input  wire logic         i_en,
    input  wire logic [W-1:0] i_d,
    output logic      [W-1:0] o_q
);
    logic [W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;
endmodule
`default_nettype wire

// ===== rtl/core/ics_delay_cell.sv =====
// Delay cell: one cleared-at-reset word that takes its neighbor's word when enabled.
`default_nettype none
module ics_delay_cell import ics_pkg::*; #(
    parameter int W = 68
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_en,
    input  wire logic [W-1:0] i_d,
    output logic      [W-1:0] o_q
);
    logic [W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_en) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;
endmodule
`default_nettype wire

// ===== bench/tb_ichimoku_cloud_signal_unit.sv =====
// Testbench for the Ichimoku cloud signal unit: candle stimulus, line and signal checks.
`timescale 1ns / 100ps
module tb_ichimoku_cloud_signal_unit;
    import ics_pkg::*;

    localparam int HIST    = 52;
    localparam int CONV_N  = 9;
    localparam int BASE_N  = 26;
    localparam int SPANB_N = 52;
    localparam int SHIFT_N = 26;
    localparam int N_RANDOM = 1250;

    typedef struct packed {
        logic [OUT_W-1:0] conv;
        logic [OUT_W-1:0] base;
        logic [OUT_W-1:0] span_a;
        logic [OUT_W-1:0] span_b;
        logic [1:0]       sig;
        logic [1:0]       strg;
    } t_lines;

    typedef struct {
        logic [IN_W-1:0]  high;
        logic [IN_W-1:0]  low;
        logic [IN_W-1:0]  close;
        bit               typed;
        logic [OUT_W-1:0] conv_base;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ics_in_if  cand_if ();
    ics_out_if line_if ();

    ichimoku_cloud_signal_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cand_if),
        .o_out   (line_if)
    );

    always #1 i_clk = ~i_clk;

    // predictor state
    logic [IN_W-1:0] high_ring [HIST];
    logic [IN_W-1:0] low_ring [HIST];
    logic [IN_W-1:0] close_ring [SHIFT_N];
    logic [34:0]     span_a_line [SHIFT_N];
    logic [34:0]     span_b_line [SHIFT_N];
    logic [34:0]     last_conv, last_base;
    int              candles_seen, hist_wr, close_wr, line_wr;

    t_lines expected_lines [$];
    int     mismatches = 0;
    int     results_seen = 0;
    int     buys = 0, sells = 0;
    int     sender_idle = 12, receiver_stall = 62;

    // Midpoint over the newest len candles, quarter ticks.
    function automatic logic [34:0] window_midpoint(int len);
        int n;
        int idx;
        logic [IN_W-1:0] hi, lo;
        n  = candles_seen < len ? candles_seen : len;
        hi = '0;
        lo = '1;
        if (n == 0) return '0;
        for (int i = 1; i <= n; i++) begin
            idx = (hist_wr + HIST - i) % HIST;
            if (high_ring[idx] > hi) hi = high_ring[idx];
            if (low_ring[idx] < lo) lo = low_ring[idx];
        end
        return ({3'b0, hi} + {3'b0, lo}) << 1;
    endfunction

    function automatic logic [1:0] cloud_grade(logic [34:0] mid, top, bottom);
        if (mid > top) return STR_STRONG;
        if (mid < top && mid > bottom) return STR_MEDIUM;
        if (mid < bottom) return STR_WEAK;
        return STR_NONE;
    endfunction

    function automatic t_lines ichimoku_advance(logic [IN_W-1:0] high, low, close);
        t_lines r;
        logic [34:0] conv, base, mid, spanb, ca, cb, top, bottom;
        logic [IN_W-1:0] back;
        logic [35:0] close_q;
        logic [1:0] sig, strg;
        bit crossed;
        high_ring[hist_wr] = high;
        low_ring[hist_wr]  = low;
        hist_wr = (hist_wr + 1) % HIST;
        close_ring[close_wr] = close;
        close_wr = (close_wr + 1) % SHIFT_N;
        if (candles_seen < HIST) candles_seen++;
        conv  = window_midpoint(CONV_N);
        base  = window_midpoint(BASE_N);
        mid   = 35'(({1'b0, conv} + {1'b0, base}) >> 1);
        spanb = window_midpoint(SPANB_N);
        ca = span_a_line[line_wr];
        cb = span_b_line[line_wr];
        span_a_line[line_wr] = mid;
        span_b_line[line_wr] = spanb;
        line_wr = (line_wr + 1) % SHIFT_N;
        top     = ca > cb ? ca : cb;
        bottom  = ca < cb ? ca : cb;
        back    = close_ring[close_wr];
        close_q = {4'b0, close} << 2;
        sig  = SIG_NONE;
        strg = STR_NONE;
        if (candles_seen >= SPANB_N) begin
            crossed = (last_conv > last_base && conv < base) ||
                      (last_conv < last_base && conv > base);
            if (crossed) begin
                if (close_q > top && conv > base && back > close) begin
                    strg = cloud_grade(mid, top, bottom);
                    sig  = strg != STR_NONE ? SIG_BUY : SIG_NONE;
                end else if (close_q < bottom && conv < base && back < close) begin
                    strg = cloud_grade(mid, top, bottom);
                    sig  = strg != STR_NONE ? SIG_SELL : SIG_NONE;
                end
            end
        end
        last_conv = conv;
        last_base = base;
        r.conv   = conv[OUT_W-1:0];
        r.base   = base[OUT_W-1:0];
        r.span_a = ca[OUT_W-1:0];
        r.span_b = cb[OUT_W-1:0];
        r.sig    = sig;
        r.strg   = strg;
        return r;
    endfunction

    // Drive one candle and hold it until the block takes the transaction.
    task automatic send_candle(logic [IN_W-1:0] high, low, close, bit typed,
                               logic [OUT_W-1:0] conv_base);
        t_lines pred;
        while ($urandom_range(99) < sender_idle) begin
            cand_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cand_if.valid       <= 1'b1;
        cand_if.high_price  <= high;
        cand_if.low_price   <= low;
        cand_if.close_price <= close;
        @(posedge i_clk);
        while (!cand_if.ready) @(posedge i_clk);
        pred = ichimoku_advance(high, low, close);
        if (typed) begin
            pred.conv   = conv_base;
            pred.base   = conv_base;
            pred.span_a = '0;
            pred.span_b = '0;
            pred.sig    = SIG_NONE;
            pred.strg   = STR_NONE;
        end
        expected_lines.push_back(pred);
    endtask

    // Output monitor
    always @(posedge i_clk) begin
        t_lines exp_r;
        bit bad;
        if (i_rst_n && line_if.valid && line_if.ready) begin
            if (expected_lines.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result with nothing pending");
            end else begin
                exp_r = expected_lines.pop_front();
                bad = (exp_r.conv !== line_if.conversion_line) ||
                      (exp_r.base !== line_if.base_line) ||
                      (exp_r.span_a !== line_if.cloud_span_a) ||
                      (exp_r.span_b !== line_if.cloud_span_b) ||
                      (exp_r.sig !== line_if.signal) || (exp_r.strg !== line_if.strength);
                if (bad) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch on result %0d:", results_seen);
                        $display("  expected conv %h base %h spanA %h spanB %h sig %0d str %0d",
                                 exp_r.conv, exp_r.base, exp_r.span_a, exp_r.span_b,
                                 exp_r.sig, exp_r.strg);
                        $display("  actual   conv %h base %h spanA %h spanB %h sig %0d str %0d",
                                 line_if.conversion_line, line_if.base_line,
                                 line_if.cloud_span_a, line_if.cloud_span_b,
                                 line_if.signal, line_if.strength);
                    end
                end
                if (exp_r.sig == SIG_BUY) buys++;
                if (exp_r.sig == SIG_SELL) sells++;
            end
            results_seen++;
        end
    end

    // Receiver back-pressure
    always @(posedge i_clk) begin
        line_if.ready <= ($urandom_range(99) >= receiver_stall);
    end

    initial begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

    initial begin
        t_row rows [$];
        longint price, trend, spread_hi, spread_lo;
        longint h, l, c;
        int seg_left;
        int walk_items;
        rows = '{
            '{32'h0, 32'h0, 32'h0, 1'b1, 34'h0},
            '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 34'h1FFFFFFFE},
            '{32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF, 1'b0, 34'h0},
            '{32'h0, 32'hFFFFFFFF, 32'h0, 1'b0, 34'h0},
            '{32'h55555555, 32'hAAAAAAAA, 32'h55555555, 1'b0, 34'h0},
            '{32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 1'b0, 34'h0},
            '{32'h80000000, 32'h7FFFFFFF, 32'h80000000, 1'b0, 34'h0},
            '{32'h00000001, 32'h00000001, 32'h00000001, 1'b0, 34'h0},
            '{32'h00001000, 32'h00000F00, 32'h00000F80, 1'b0, 34'h0},
            '{32'h00001100, 32'h00001000, 32'h00001080, 1'b0, 34'h0},
            '{32'h00001200, 32'h00001100, 32'h00001180, 1'b0, 34'h0},
            '{32'h00001300, 32'h00001200, 32'h00001280, 1'b0, 34'h0},
            '{32'hFFFFFFFE, 32'hFFFFFFF0, 32'hFFFFFFF8, 1'b0, 34'h0},
            '{32'h00000000, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 34'h0},
            '{32'h12345678, 32'h12345678, 32'h12345678, 1'b0, 34'h0},
            '{32'h12345678, 32'h12345678, 32'h12345678, 1'b0, 34'h0}
        };
        for (int i = 0; i < HIST; i++) begin
            high_ring[i] = '0;
            low_ring[i]  = '0;
        end
        for (int i = 0; i < SHIFT_N; i++) begin
            close_ring[i]  = '0;
            span_a_line[i] = '0;
            span_b_line[i] = '0;
        end
        last_conv = '0;
        last_base = '0;
        candles_seen = 0;
        hist_wr = 0;
        close_wr = 0;
        line_wr = 0;

        i_rst_n             <= 1'b0;
        cand_if.valid       <= 1'b0;
        cand_if.high_price  <= '0;
        cand_if.low_price   <= '0;
        cand_if.close_price <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i])
            send_candle(rows[i].high, rows[i].low, rows[i].close, rows[i].typed,
                        rows[i].conv_base);

        // Trending walks drive the crosses; plain noise fills in the bit patterns.
        price = 64'd100000;
        trend = 0;
        seg_left = 0;
        walk_items = 0;
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 3) begin
                sender_idle = 62;
                receiver_stall = 12;
            end else if (n == 2 * N_RANDOM / 3) begin
                sender_idle = 0;
                receiver_stall = 0;
            end
            if ($urandom_range(99) < 12) begin
                send_candle($urandom, $urandom, $urandom, 1'b0, '0);
            end else begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(40, 5);
                    trend = longint'($urandom_range(800)) - 400;
                    if ($urandom_range(9) == 0) trend = 0;
                    if ($urandom_range(49) == 0)
                        price = $urandom_range(32'hFFFF0000, 32'h10000);
                end
                seg_left--;
                price = price + trend + longint'($urandom_range(100)) - 50;
                if (price < 64'h1000) price = 64'h1000;
                if (price > 64'hFFFFF000) price = 64'hFFFFF000;
                spread_hi = trend == 0 && seg_left[0] ? 0 : $urandom_range(300);
                spread_lo = trend == 0 && seg_left[0] ? 0 : $urandom_range(300);
                h = price + spread_hi;
                l = price - spread_lo;
                c = l + $urandom_range(int'(h - l));
                send_candle(h[31:0], l[31:0], c[31:0], 1'b0, '0);
                walk_items++;
            end
        end
        cand_if.valid <= 1'b0;

        while (expected_lines.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);

        $display("covered %0d candles (%0d from trending walks), %0d results checked",
                 rows.size() + N_RANDOM, walk_items, results_seen);
        $display("signals seen: %0d buy, %0d sell; mismatches %0d", buys, sells, mismatches);
        if (mismatches == 0 && expected_lines.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/core/ics_pkg.sv
rtl/core/ics_if.sv
rtl/core/ics_cell.sv
rtl/core/ics_delay_cell.sv
rtl/core/ichimoku_cloud_signal_unit.sv
bench/tb_ichimoku_cloud_signal_unit.sv
